### rtl/core/tour_length_evaluator_defines.svh
`ifndef TOUR_LENGTH_EVALUATOR_DEFINES_SVH
`define TOUR_LENGTH_EVALUATOR_DEFINES_SVH

// Both macros expect clk_i and rst_ni to be visible where they are used.
`define TLE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tour length evaluator property violated");

`define TLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tour length evaluator property violated");

`endif

### rtl/core/tle_pkg.sv
package tle_pkg;

  localparam int unsigned MAX_CITIES = 128;
  localparam int unsigned ADDR_W     = $clog2(MAX_CITIES);
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned SQ_W       = 2 * COORD_BITS;
  localparam int unsigned SUM_W      = SQ_W + 1;
  localparam int unsigned ROOT_W     = (SUM_W + 1) / 2;
  localparam int unsigned RAD_W      = 2 * ROOT_W;
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned LEN_W      = 32;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TOUR = 1'b1
  } tle_req_type_e;

  typedef logic [COORD_BITS-1:0] tle_coord_t;

  typedef struct packed {
    tle_req_type_e    req_type;
    logic [IDX_W-1:0] city_index;
    tle_coord_t       coord_x;
    tle_coord_t       coord_y;
    logic             is_last;
  } tle_req_t;

  typedef struct packed {
    logic [LEN_W-1:0] tour_length;
    logic             saturated;
  } tle_rsp_t;

  typedef struct packed {
    tle_coord_t x;
    tle_coord_t y;
  } tle_point_t;

  typedef struct packed {
    logic last;
    logic start;
  } tle_tag_t;

  typedef struct packed {
    tle_tag_t   tag;
    tle_coord_t dx_step;
    tle_coord_t dy_step;
    tle_coord_t dx_close;
    tle_coord_t dy_close;
  } tle_diff_t;

  typedef struct packed {
    tle_tag_t          tag;
    logic [ROOT_W-1:0] len_step;
    logic [ROOT_W-1:0] len_close;
  } tle_len_t;

endpackage

### rtl/core/tle_front.sv
module tle_front import tle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  logic      req_valid_i,
  input  tle_req_t  req_i,
  output logic      diff_valid_o,
  output tle_diff_t diff_o
);

  tle_point_t mem_q [MAX_CITIES];
  logic       in_range;
  logic       take_load;
  logic       take_tour;
  logic       s1_valid_q;
  logic       s1_last_q;
  tle_point_t s1_pt_q;
  tle_point_t first_q;
  tle_point_t prev_q;
  logic       open_q;
  tle_point_t from_pt;
  tle_point_t close_pt;
  tle_diff_t  diff_d;
  logic       diff_valid_q;
  tle_diff_t  diff_q;

  function automatic tle_coord_t abs_diff(input tle_coord_t a, input tle_coord_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign in_range  = ({1'b0, req_i.city_index} < (IDX_W + 1)'(MAX_CITIES));
  assign take_load = req_valid_i && adv_i && (req_i.req_type == REQ_LOAD);
  assign take_tour = req_valid_i && adv_i && (req_i.req_type == REQ_TOUR);

  always_ff @(posedge clk_i) begin
    if (take_load && in_range) begin
      mem_q[req_i.city_index[ADDR_W-1:0]] <= tle_point_t'({req_i.coord_x, req_i.coord_y});
    end
    if (take_tour) begin
      s1_last_q <= req_i.is_last;
      s1_pt_q   <= in_range ? mem_q[req_i.city_index[ADDR_W-1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      first_q    <= '0;
      prev_q     <= '0;
      open_q     <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= take_tour;
      if (s1_valid_q) begin
        prev_q <= s1_pt_q;
        if (!open_q) begin
          first_q <= s1_pt_q;
        end
        open_q <= !s1_last_q;
      end
    end
  end

  // A tour that starts here takes this city as both its previous and its first point.
  always_comb begin
    from_pt         = open_q ? prev_q : s1_pt_q;
    close_pt        = open_q ? first_q : s1_pt_q;
    diff_d.tag.last = s1_last_q;
    diff_d.tag.start = !open_q;
    diff_d.dx_step  = abs_diff(from_pt.x, s1_pt_q.x);
    diff_d.dy_step  = abs_diff(from_pt.y, s1_pt_q.y);
    diff_d.dx_close = s1_last_q ? abs_diff(s1_pt_q.x, close_pt.x) : '0;
    diff_d.dy_close = s1_last_q ? abs_diff(s1_pt_q.y, close_pt.y) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_valid_q <= 1'b0;
    end else if (adv_i) begin
      diff_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      diff_q <= diff_d;
    end
  end

  assign diff_valid_o = diff_valid_q;
  assign diff_o       = diff_q;

endmodule

### rtl/core/tle_dist_pipe.sv
module tle_dist_pipe import tle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  logic      diff_valid_i,
  input  tle_diff_t diff_i,
  output logic      len_valid_o,
  output tle_len_t  len_o
);

  localparam int unsigned NUM_LANES = 2;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } tle_sqrt_t;

  tle_coord_t        dx_in [NUM_LANES];
  tle_coord_t        dy_in [NUM_LANES];
  logic              sq_valid_q;
  tle_tag_t          sq_tag_q;
  logic [SQ_W-1:0]   sqx_q [NUM_LANES];
  logic [SQ_W-1:0]   sqy_q [NUM_LANES];
  logic              sum_valid_q;
  tle_tag_t          sum_tag_q;
  logic [SUM_W-1:0]  sum_q [NUM_LANES];
  logic [ROOT_W-1:0] st_valid_q;
  tle_tag_t          st_tag_q [ROOT_W];
  tle_sqrt_t         st_q [NUM_LANES][ROOT_W];
  tle_sqrt_t         st_d [NUM_LANES][ROOT_W];
  logic [ROOT_W-1:0] len_d [NUM_LANES];
  logic              len_valid_q;
  tle_len_t          len_q;

  // One result bit per stage of a restoring square root.
  function automatic tle_sqrt_t sqrt_step(input tle_sqrt_t a);
    tle_sqrt_t        r;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
    trial  = {a.root, 2'b01};
    r.rad  = {a.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  assign dx_in[0] = diff_i.dx_step;
  assign dy_in[0] = diff_i.dy_step;
  assign dx_in[1] = diff_i.dx_close;
  assign dy_in[1] = diff_i.dy_close;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      st_d[l][0] = sqrt_step(tle_sqrt_t'{rad: RAD_W'(sum_q[l]), rem: '0, root: '0});
      for (int k = 1; k < ROOT_W; k++) begin
        st_d[l][k] = sqrt_step(st_q[l][k-1]);
      end
    end
  end

  // The root is rounded up when the remainder exceeds it, since s > r*(r+1) then.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      len_d[l] = st_q[l][ROOT_W-1].root
               + ROOT_W'(st_q[l][ROOT_W-1].rem > REM_W'(st_q[l][ROOT_W-1].root));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
      st_valid_q  <= '0;
      len_valid_q <= 1'b0;
    end else if (adv_i) begin
      sq_valid_q  <= diff_valid_i;
      sum_valid_q <= sq_valid_q;
      st_valid_q  <= {st_valid_q[ROOT_W-2:0], sum_valid_q};
      len_valid_q <= st_valid_q[ROOT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sq_tag_q  <= diff_i.tag;
      sum_tag_q <= sq_tag_q;
      for (int l = 0; l < NUM_LANES; l++) begin
        sqx_q[l] <= SQ_W'(dx_in[l]) * SQ_W'(dx_in[l]);
        sqy_q[l] <= SQ_W'(dy_in[l]) * SQ_W'(dy_in[l]);
        sum_q[l] <= SUM_W'(sqx_q[l]) + SUM_W'(sqy_q[l]);
      end
      st_q        <= st_d;
      st_tag_q[0] <= sum_tag_q;
      for (int k = 1; k < ROOT_W; k++) begin
        st_tag_q[k] <= st_tag_q[k-1];
      end
      len_q.tag       <= st_tag_q[ROOT_W-1];
      len_q.len_step  <= len_d[0];
      len_q.len_close <= len_d[1];
    end
  end

  assign len_valid_o = len_valid_q;
  assign len_o       = len_q;

endmodule

### rtl/core/tle_accum.sv
module tle_accum import tle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     len_valid_i,
  input  tle_len_t len_i,
  output logic     adv_o,
  output logic     rsp_valid_o,
  input  logic     rsp_stall_i,
  output tle_rsp_t rsp_o
);

  logic [LEN_W-1:0]   run_q;
  logic               sat_q;
  logic [LEN_W-1:0]   base;
  logic               sat_base;
  logic [LEN_W+1:0]   total;
  logic               over;
  logic [LEN_W-1:0]   sum;
  logic               sat_new;
  logic               take;
  logic               rsp_valid_q;
  tle_rsp_t           rsp_q;

  // The pipeline only waits when a finished tour meets a full, stalled output register.
  assign adv_o = !(len_valid_i && len_i.tag.last && rsp_valid_q && rsp_stall_i);
  assign take  = adv_o && len_valid_i;

  // Clamping after each edge equals clamping the whole sum, as all edges are nonnegative.
  always_comb begin
    base     = len_i.tag.start ? '0 : run_q;
    sat_base = len_i.tag.start ? 1'b0 : sat_q;
    total    = (LEN_W + 2)'(base) + (LEN_W + 2)'(len_i.len_step)
             + (LEN_W + 2)'(len_i.len_close);
    over     = |total[LEN_W+1:LEN_W];
    sum      = over ? '1 : total[LEN_W-1:0];
    sat_new  = sat_base || over;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      sat_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (take) begin
        run_q <= sum;
        sat_q <= sat_new;
      end
      if (take && len_i.tag.last) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && len_i.tag.last) begin
      rsp_q.tour_length <= sum;
      rsp_q.saturated   <= sat_new;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### rtl/core/tour_length_evaluator.sv
// Closed tour length evaluator.
// Requests arrive on req_valid_i/req_stall_o/req_i. A load request writes the
// coordinates of one city into the on-chip table. A tour request names the
// next city of the current tour; the request flagged is_last closes the tour
// back to its first city and produces one response on rsp_valid_o/
// rsp_stall_i/rsp_o with the length in Q24.8 and a saturation flag.
// One request is taken every cycle while req_stall_o is low. A tour response
// is built from its closing request in order: the table is read at the
// accepting edge, then come the register for the tour bookkeeping, the
// squares and their sum, the one bit per stage square root, the rounding
// register and the output register.
// Two distance units run side by side so that the closing edge costs nothing.
// While the output register holds a stalled response the pipeline keeps
// moving and taking requests; it halts only when a second response reaches
// its last stage, and req_stall_o is then high.
// Reset clears the pipeline, ends any open tour and leaves no response
// pending; the city table keeps no reset value and must be loaded first.
module tour_length_evaluator import tle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_stall_o,
  input  tle_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_stall_i,
  output tle_rsp_t rsp_o
);

  logic      adv;
  logic      diff_valid;
  tle_diff_t diff;
  logic      len_valid;
  tle_len_t  len;

  assign req_stall_o = !adv;

  tle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .req_valid_i  (req_valid_i),
    .req_i        (req_i),
    .diff_valid_o (diff_valid),
    .diff_o       (diff)
  );

  tle_dist_pipe u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .diff_valid_i (diff_valid),
    .diff_i       (diff),
    .len_valid_o  (len_valid),
    .len_o        (len)
  );

  tle_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_valid_i (len_valid),
    .len_i       (len),
    .adv_o       (adv),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule

### rtl/core/tle_checker.sv
`include "tour_length_evaluator_defines.svh"

module tle_checker import tle_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     req_stall_o,
  input logic     rsp_valid_o,
  input logic     rsp_stall_i,
  input tle_rsp_t rsp_o
);

  `TLE_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid_o && rsp_stall_i, rsp_valid_o)
  `TLE_ASSERT_NEXT(a_rsp_payload_hold, rsp_valid_o && rsp_stall_i, $stable(rsp_o))
  `TLE_ASSERT_IMPLY(a_sat_means_max, rsp_valid_o && rsp_o.saturated, rsp_o.tour_length == '1)
  `TLE_ASSERT_IMPLY(a_stall_only_behind_rsp, req_stall_o, rsp_valid_o && rsp_stall_i)

endmodule

bind tour_length_evaluator tle_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_stall_o (req_stall_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_o       (rsp_o)
);

### sim/tb.sv
module tb;
  import tle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_REQS = 1500;
  localparam int unsigned TAIL_CYCLES = 40;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     req_valid_i = 1'b0;
  logic     req_stall_o;
  tle_req_t req_i = '0;
  logic     rsp_valid_o;
  logic     rsp_stall_i = 1'b0;
  tle_rsp_t rsp_o;

  tle_point_t  city_map [MAX_CITIES];
  bit          city_known [MAX_CITIES];
  tle_point_t  tour_first;
  tle_point_t  tour_prev;
  logic [31:0] tour_sum;
  bit          tour_sat;
  bit          tour_active;
  tle_rsp_t    tour_lengths_due [$];

  int          req_gap_max = 0;
  int          rsp_gap_max = 0;
  int          long_hold_cycles = 0;
  int          errors = 0;
  int          requests_sent = 0;
  int          tours_checked = 0;
  int          saturated_tours = 0;
  int unsigned cycle_count = 0;

  tour_length_evaluator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Edge length in Q.8: the square root of dx*dx + dy*dy, rounded to nearest.
  function automatic longint unsigned edge_q8(input tle_point_t a, input tle_point_t b);
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    dx = (a.x > b.x) ? a.x - b.x : b.x - a.x;
    dy = (a.y > b.y) ? a.y - b.y : b.y - a.y;
    sq = dx * dx + dy * dy;
    root = 0;
    for (int bit_pos = 17; bit_pos >= 0; bit_pos--) begin
      trial = root | (64'd1 << bit_pos);
      if (trial * trial <= sq) begin
        root = trial;
      end
    end
    if (sq > root * (root + 1)) begin
      root++;
    end
    return root;
  endfunction

  task automatic accumulate_edge(input longint unsigned len);
    longint unsigned total;
    total = longint'(tour_sum) + len;
    if (total > 64'h0000_0000_FFFF_FFFF) begin
      total = 64'h0000_0000_FFFF_FFFF;
      tour_sat = 1'b1;
    end
    tour_sum = total[31:0];
  endtask

  task automatic predict_request(input tle_req_t r);
    tle_point_t p;
    tle_rsp_t   due;
    if (r.req_type == REQ_LOAD) begin
      city_map[r.city_index] = '{x: r.coord_x, y: r.coord_y};
      city_known[r.city_index] = 1'b1;
    end else begin
      p = city_map[r.city_index];
      if (!tour_active) begin
        tour_first = p;
        tour_prev = p;
        tour_sum = '0;
        tour_sat = 1'b0;
        tour_active = 1'b1;
      end else begin
        accumulate_edge(edge_q8(tour_prev, p));
        tour_prev = p;
      end
      if (r.is_last) begin
        accumulate_edge(edge_q8(tour_prev, tour_first));
        tour_active = 1'b0;
        due.tour_length = tour_sum;
        due.saturated = tour_sat;
        tour_lengths_due.push_back(due);
      end
    end
  endtask

  task automatic check_tour_length(input tle_rsp_t got);
    tle_rsp_t want;
    if (tour_lengths_due.size() == 0) begin
      $error("response with no tour outstanding: tour_length %0h", got.tour_length);
      errors++;
    end else begin
      want = tour_lengths_due.pop_front();
      if (got.tour_length !== want.tour_length) begin
        $error("tour_length expected %0h actual %0h", want.tour_length, got.tour_length);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated expected %0b actual %0b", want.saturated, got.saturated);
        errors++;
      end
      tours_checked++;
      if (want.saturated) begin
        saturated_tours++;
      end
    end
  endtask

  function automatic tle_coord_t coord_draw();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return tle_coord_t'($urandom);
    endcase
  endfunction

  function automatic tle_req_t load_item(input int idx, input tle_coord_t x, input tle_coord_t y,
                                         input logic last);
    tle_req_t r;
    r.req_type = REQ_LOAD;
    r.city_index = idx[IDX_W-1:0];
    r.coord_x = x;
    r.coord_y = y;
    r.is_last = last;
    return r;
  endfunction

  // Coordinates on a tour request are don't-care, so they carry noise.
  function automatic tle_req_t step_item(input int idx, input logic last);
    tle_req_t r;
    r.req_type = REQ_TOUR;
    r.city_index = idx[IDX_W-1:0];
    r.coord_x = tle_coord_t'($urandom);
    r.coord_y = tle_coord_t'($urandom);
    r.is_last = last;
    return r;
  endfunction

  function automatic int city_pick();
    int idx;
    do begin
      idx = $urandom_range(0, MAX_CITIES - 1);
    end while (!city_known[idx]);
    return idx;
  endfunction

  task automatic send_request(input tle_req_t r);
    int   gap;
    logic stalled;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do begin
      @(negedge clk_i);
      stalled = req_stall_o;
      @(posedge clk_i);
    end while (stalled);
    predict_request(r);
    requests_sent++;
  endtask

  task automatic wait_for_tours();
    req_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (tour_lengths_due.size() != 0);
  endtask

  task automatic test_directed_cases();
    req_gap_max = 0;
    rsp_gap_max = 2;
    send_request(load_item(0, 16'h0000, 16'h0000, 1'b0));
    // The last flag on a load request is ignored.
    send_request(load_item(127, 16'hFFFF, 16'hFFFF, 1'b1));
    send_request(load_item(1, 16'hFFFF, 16'h0000, 1'b0));
    send_request(load_item(2, 16'h0000, 16'hFFFF, 1'b0));
    send_request(load_item(85, 16'h5555, 16'hAAAA, 1'b0));
    send_request(load_item(42, 16'hAAAA, 16'h5555, 1'b1));
    send_request(step_item(127, 1'b1));
    send_request(step_item(0, 1'b0));
    send_request(step_item(127, 1'b1));
    send_request(step_item(0, 1'b0));
    send_request(step_item(1, 1'b0));
    send_request(step_item(127, 1'b0));
    send_request(step_item(2, 1'b1));
    // Reloading cities mid-tour: the closing edge still uses the old first point.
    send_request(step_item(85, 1'b0));
    send_request(load_item(85, 16'h0100, 16'h0200, 1'b0));
    send_request(step_item(42, 1'b0));
    send_request(step_item(85, 1'b0));
    send_request(step_item(42, 1'b1));
    wait_for_tours();
  endtask

  task automatic test_response_backpressure();
    req_gap_max = 0;
    rsp_gap_max = 0;
    long_hold_cycles = 300;
    for (int k = 0; k < 90; k++) begin
      send_request(step_item(city_pick(), (k % 3) != 0));
    end
    wait_for_tours();
  endtask

  task automatic test_random_traffic();
    int sent;
    int tour_len;
    int burst;
    sent = 0;
    while (sent < RANDOM_REQS) begin
      if ($urandom_range(0, 7) == 0) begin
        req_gap_max = $urandom_range(0, 1) ? 13 : 0;
        rsp_gap_max = $urandom_range(0, 1) ? 13 : 0;
      end
      if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          send_request(load_item($urandom_range(0, MAX_CITIES - 1), coord_draw(), coord_draw(),
                                 logic'($urandom_range(0, 1))));
          sent++;
        end
      end else begin
        tour_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
        for (int k = 0; k < tour_len; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_request(load_item($urandom_range(0, MAX_CITIES - 1), coord_draw(),
                                   coord_draw(), logic'($urandom_range(0, 1))));
            sent++;
          end
          send_request(step_item(city_pick(), k == tour_len - 1));
          sent++;
        end
      end
    end
    wait_for_tours();
  endtask

  initial begin : response_sink
    int       hold;
    logic     got_valid;
    tle_rsp_t got;
    @(posedge rst_ni);
    forever begin
      if (long_hold_cycles > 0) begin
        hold = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        hold = $urandom_range(0, rsp_gap_max);
      end
      if (hold > 0) begin
        rsp_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        rsp_stall_i <= 1'b0;
      end
      do begin
        @(negedge clk_i);
        got_valid = rsp_valid_o;
        got = rsp_o;
        @(posedge clk_i);
      end while (!got_valid);
      check_tour_length(got);
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_response_backpressure();
    test_random_traffic();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tour_lengths_due.size() != 0) begin
      $error("%0d tour lengths never arrived", tour_lengths_due.size());
      errors++;
    end
    $display("Sent %0d requests, checked %0d closed tours (%0d saturated).",
             requests_sent, tours_checked, saturated_tours);
    $display("Covered corner points, mid-tour reloads, one-city tours and output backpressure.");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tle_pkg.sv
rtl/core/tle_front.sv
rtl/core/tle_dist_pipe.sv
rtl/core/tle_accum.sv
rtl/core/tour_length_evaluator.sv
rtl/core/tle_checker.sv
sim/tb.sv
